// ----- sv/serial_frame_deframer_assert.svh -----
// Assertion helpers shared by the deframer modules.
`ifndef SERIAL_FRAME_DEFRAMER_ASSERT_SVH
`define SERIAL_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sfd_pkg.sv -----
`default_nettype none

package sfd_pkg;

  localparam logic [7:0]  SYNC_A        = 8'h55;
  localparam logic [7:0]  SYNC_B        = 8'hAA;
  localparam logic [7:0]  TRAILER       = 8'h7D;
  localparam logic [7:0]  WHEEL_ID      = 8'h02;
  localparam logic [7:0]  MIN_LEN       = 8'd2;
  localparam logic [19:0] GAP_MAX       = 20'hFFFFF;
  localparam logic [19:0] TIMEOUT_RESET = 20'd100000;

  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_WHEEL   = 3'd1;
  localparam logic [2:0] ST_OTHER   = 3'd2;
  localparam logic [2:0] ST_CSUM    = 3'd3;
  localparam logic [2:0] ST_TRAIL   = 3'd4;
  localparam logic [2:0] ST_BADLEN  = 3'd5;
  localparam logic [2:0] ST_TIMEOUT = 3'd6;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_SYNC2  = 3'd1,
    PH_LEN    = 3'd2,
    PH_BODY   = 3'd3,
    PH_CSUM   = 3'd4,
    PH_TRAIL  = 3'd5,
    PH_BADLEN = 3'd6
  } phase_t;

  typedef enum logic {
    ITEM_BYTE = 1'b0,
    ITEM_TICK = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       body_valid;
    logic [7:0] body_byte;
    logic [7:0] body_index;
  } out_item_t;

  // Queue entry: the word as received plus the front end's classification.
  typedef struct packed {
    item_kind_t kind;
    logic [7:0] data;
    logic       is_sync_a;
    logic       is_sync_b;
    logic       is_trailer;
  } q_item_t;

endpackage

`default_nettype wire

// ----- sv/sfd_front.sv -----
`default_nettype none

`include "serial_frame_deframer_assert.svh"

module sfd_front #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire sfd_pkg::in_item_t in_data,
  output logic                  q_valid,
  output sfd_pkg::q_item_t      q_item,
  input  wire logic             q_pop
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  sfd_pkg::q_item_t mem [DEPTH];
  sfd_pkg::q_item_t classified;
  logic [IW-1:0]    wr_ptr;
  logic [IW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign in_stall = (count == CW'(DEPTH));
  assign q_valid  = (count != '0);
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_item   = mem[rd_ptr];

  always_comb begin
    classified.kind       = in_data.cmd ? sfd_pkg::ITEM_TICK : sfd_pkg::ITEM_BYTE;
    classified.data       = in_data.rx_byte;
    classified.is_sync_a  = (in_data.rx_byte == sfd_pkg::SYNC_A);
    classified.is_sync_b  = (in_data.rx_byte == sfd_pkg::SYNC_B);
    classified.is_trailer = (in_data.rx_byte == sfd_pkg::TRAILER);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SFD_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH), "queue count overrun")

endmodule

`default_nettype wire

// ----- sv/sfd_back.sv -----
`default_nettype none

`include "serial_frame_deframer_assert.svh"

module sfd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [19:0]       cfg_data,
  input  wire logic              q_valid,
  input  wire sfd_pkg::q_item_t  q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sfd_pkg::out_item_t     out_data
);

  sfd_pkg::phase_t    phase, phase_next;
  logic [7:0]         body_length, body_length_next;
  logic [8:0]         bytes_seen, bytes_seen_next;
  logic [7:0]         running_sum, running_sum_next;
  logic [7:0]         first_body_byte, first_body_byte_next;
  logic [7:0]         second_body_byte, second_body_byte_next;
  logic [19:0]        gap_counter, gap_counter_next;
  logic [19:0]        timeout_ticks;
  sfd_pkg::out_item_t out_next;
  logic [8:0]         seen_inc;
  logic               go;

  assign cfg_ready = 1'b1;
  // An item is retired whenever the output register is free or being emptied.
  assign go       = q_valid && (!out_valid || !out_stall);
  assign q_pop    = go;
  assign seen_inc = bytes_seen + 9'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= sfd_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      timeout_ticks <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= sfd_pkg::PH_HUNT;
      body_length      <= '0;
      bytes_seen       <= '0;
      running_sum      <= '0;
      first_body_byte  <= '0;
      second_body_byte <= '0;
      gap_counter      <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (go) begin
        phase            <= phase_next;
        body_length      <= body_length_next;
        bytes_seen       <= bytes_seen_next;
        running_sum      <= running_sum_next;
        first_body_byte  <= first_body_byte_next;
        second_body_byte <= second_body_byte_next;
        gap_counter      <= gap_counter_next;
        out_valid        <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data <= out_next;
    end
  end

  always_comb begin
    phase_next            = phase;
    body_length_next      = body_length;
    bytes_seen_next       = bytes_seen;
    running_sum_next      = running_sum;
    first_body_byte_next  = first_body_byte;
    second_body_byte_next = second_body_byte;
    gap_counter_next      = gap_counter;
    out_next              = '0;
    out_next.status       = sfd_pkg::ST_NONE;

    if (q_item.kind == sfd_pkg::ITEM_TICK) begin
      if (gap_counter != sfd_pkg::GAP_MAX) begin
        gap_counter_next = gap_counter + 20'd1;
      end
      if (phase != sfd_pkg::PH_HUNT && gap_counter_next > timeout_ticks) begin
        phase_next      = sfd_pkg::PH_HUNT;
        out_next.status = sfd_pkg::ST_TIMEOUT;
      end
    end else begin
      unique case (phase)
        sfd_pkg::PH_SYNC2: begin
          if (q_item.is_sync_b) begin
            phase_next = sfd_pkg::PH_LEN;
          end else if (!q_item.is_sync_a) begin
            phase_next = sfd_pkg::PH_HUNT;
          end
        end
        sfd_pkg::PH_LEN: begin
          body_length_next      = q_item.data;
          bytes_seen_next       = '0;
          running_sum_next      = '0;
          first_body_byte_next  = '0;
          second_body_byte_next = '0;
          phase_next = (q_item.data < sfd_pkg::MIN_LEN) ? sfd_pkg::PH_BADLEN
                                                       : sfd_pkg::PH_BODY;
        end
        sfd_pkg::PH_BADLEN: begin
          phase_next      = sfd_pkg::PH_HUNT;
          out_next.status = sfd_pkg::ST_BADLEN;
        end
        sfd_pkg::PH_BODY: begin
          if (bytes_seen[7:0] == 8'd0) begin
            first_body_byte_next = q_item.data;
          end else if (bytes_seen[7:0] == 8'd1) begin
            second_body_byte_next = q_item.data;
          end
          running_sum_next    = running_sum + q_item.data;
          out_next.body_valid = 1'b1;
          out_next.body_byte  = q_item.data;
          out_next.body_index = bytes_seen[7:0];
          bytes_seen_next     = seen_inc;
          if (seen_inc >= {1'b0, body_length}) begin
            phase_next = sfd_pkg::PH_CSUM;
          end
        end
        sfd_pkg::PH_CSUM: begin
          running_sum_next = running_sum - q_item.data;
          phase_next       = sfd_pkg::PH_TRAIL;
        end
        sfd_pkg::PH_TRAIL: begin
          if (!q_item.is_trailer) begin
            out_next.status = sfd_pkg::ST_TRAIL;
          end else if (running_sum != 8'd0) begin
            out_next.status = sfd_pkg::ST_CSUM;
          end else if (first_body_byte == sfd_pkg::WHEEL_ID &&
                       second_body_byte == sfd_pkg::WHEEL_ID) begin
            out_next.status = sfd_pkg::ST_WHEEL;
          end else begin
            out_next.status = sfd_pkg::ST_OTHER;
          end
          phase_next = sfd_pkg::PH_HUNT;
        end
        default: begin
          if (q_item.is_sync_a) begin
            phase_next       = sfd_pkg::PH_SYNC2;
            gap_counter_next = '0;
          end else begin
            phase_next = sfd_pkg::PH_HUNT;
          end
        end
      endcase
    end
  end

  `SFD_ASSERT_NOW(a_body_no_status, clk, rst, out_valid && out_data.body_valid, out_data.status == sfd_pkg::ST_NONE, "body word carries a status")
  `SFD_ASSERT_NOW(a_body_in_range, clk, rst, phase == sfd_pkg::PH_BODY, bytes_seen < {1'b0, body_length}, "body count past length")
  `SFD_ASSERT_NEXT(a_tick_no_body, clk, rst, go && q_item.kind == sfd_pkg::ITEM_TICK, out_valid && !out_data.body_valid, "tick produced a body word")

endmodule

`default_nettype wire

// ----- sv/serial_frame_deframer.sv -----
// Serial frame deframer.
// The input channel (in_valid, in_stall, in_data) takes one word per cycle while in_stall
// is low: either a received byte (cmd 0) or a one-microsecond time tick (cmd 1).
// The block hunts for the sync pair 0x55 0xAA, reads a length byte, passes each body
// byte on with its index, and reports one status at the trailer: good wheel frame, good
// other frame, checksum error or trailer error. Short lengths and timeouts are reported
// as well. Every accepted word yields exactly one output word on (out_valid, out_stall,
// out_data); most carry status none.
// The timeout register is written through cfg_valid/cfg_ready/cfg_data, which is
// always ready; write it only while the block is idle.
// A word accepted is written into the front queue, and the back end parses it into the
// output register once that register is free or being emptied. The parser takes one word
// per cycle while out_stall is low; the front queue lets the input keep flowing for
// QUEUE_DEPTH words while the receiver holds out_stall, then in_stall rises.
// A stalled output word holds until taken.
// Reset (rst, synchronous) empties the queue, returns the parser to sync hunting,
// clears the frame counters and loads the timeout with 100000 ticks.
`default_nettype none

module serial_frame_deframer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire sfd_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sfd_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [19:0]        cfg_data
);

  // Classified words waiting for the parser.
  logic             q_valid;
  logic             q_pop;
  sfd_pkg::q_item_t q_item;

  // The front end classifies each word and buffers it.
  sfd_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // The back end runs the frame state machine and owns the output register.
  sfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- tb/serial_frame_deframer_checker.sv -----
`default_nettype none

module serial_frame_deframer_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire sfd_pkg::in_item_t  in_data,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire sfd_pkg::out_item_t out_data,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [19:0]        cfg_data,
  output int unsigned             mismatches,
  output int unsigned             results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the parser state and the timeout register.
  logic [19:0]      timeout_limit;
  sfd_pkg::phase_t  parse_phase;
  logic [7:0]       frame_len;
  logic [8:0]       body_count;
  logic [7:0]       body_sum;
  logic [7:0]       lead_id0;
  logic [7:0]       lead_id1;
  logic [19:0]      tick_gap;

  sfd_pkg::out_item_t parse_results_due[$];
  sfd_pkg::out_item_t due;
  int unsigned        fail_total = 0;

  // Advances the shadow parser by one word and returns the word it must emit.
  function automatic sfd_pkg::out_item_t parse_word(sfd_pkg::in_item_t w);
    sfd_pkg::out_item_t r;
    r.status     = sfd_pkg::ST_NONE;
    r.body_valid = 1'b0;
    r.body_byte  = 8'd0;
    r.body_index = 8'd0;
    if (w.cmd == sfd_pkg::ITEM_TICK) begin
      if (tick_gap != sfd_pkg::GAP_MAX) tick_gap = tick_gap + 20'd1;
      if (parse_phase != sfd_pkg::PH_HUNT && tick_gap > timeout_limit) begin
        parse_phase = sfd_pkg::PH_HUNT;
        r.status    = sfd_pkg::ST_TIMEOUT;
      end
      return r;
    end
    case (parse_phase)
      sfd_pkg::PH_SYNC2: begin
        if (w.rx_byte == sfd_pkg::SYNC_B) parse_phase = sfd_pkg::PH_LEN;
        else if (w.rx_byte != sfd_pkg::SYNC_A) parse_phase = sfd_pkg::PH_HUNT;
      end
      sfd_pkg::PH_LEN: begin
        frame_len  = w.rx_byte;
        body_count = 9'd0;
        body_sum   = 8'd0;
        lead_id0   = 8'd0;
        lead_id1   = 8'd0;
        if (w.rx_byte < sfd_pkg::MIN_LEN) parse_phase = sfd_pkg::PH_BADLEN;
        else parse_phase = sfd_pkg::PH_BODY;
      end
      sfd_pkg::PH_BADLEN: begin
        parse_phase = sfd_pkg::PH_HUNT;
        r.status    = sfd_pkg::ST_BADLEN;
      end
      sfd_pkg::PH_BODY: begin
        if (body_count[7:0] == 8'd0) lead_id0 = w.rx_byte;
        else if (body_count[7:0] == 8'd1) lead_id1 = w.rx_byte;
        body_sum     = body_sum + w.rx_byte;
        r.body_valid = 1'b1;
        r.body_byte  = w.rx_byte;
        r.body_index = body_count[7:0];
        body_count   = body_count + 9'd1;
        if (body_count >= {1'b0, frame_len}) parse_phase = sfd_pkg::PH_CSUM;
      end
      sfd_pkg::PH_CSUM: begin
        body_sum    = body_sum - w.rx_byte;
        parse_phase = sfd_pkg::PH_TRAIL;
      end
      sfd_pkg::PH_TRAIL: begin
        if (w.rx_byte != sfd_pkg::TRAILER) r.status = sfd_pkg::ST_TRAIL;
        else if (body_sum != 8'd0) r.status = sfd_pkg::ST_CSUM;
        else if (lead_id0 == sfd_pkg::WHEEL_ID && lead_id1 == sfd_pkg::WHEEL_ID)
          r.status = sfd_pkg::ST_WHEEL;
        else r.status = sfd_pkg::ST_OTHER;
        parse_phase = sfd_pkg::PH_HUNT;
      end
      default: begin
        if (w.rx_byte == sfd_pkg::SYNC_A) begin
          parse_phase = sfd_pkg::PH_SYNC2;
          tick_gap    = 20'd0;
        end else begin
          parse_phase = sfd_pkg::PH_HUNT;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      timeout_limit = sfd_pkg::TIMEOUT_RESET;
      parse_phase   = sfd_pkg::PH_HUNT;
      frame_len     = 8'd0;
      body_count    = 9'd0;
      body_sum      = 8'd0;
      lead_id0      = 8'd0;
      lead_id1      = 8'd0;
      tick_gap      = 20'd0;
      parse_results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) timeout_limit = cfg_data;
      // A result never leaves in the cycle its word is accepted, so compare first.
      if (out_valid && !out_stall) begin
        if (parse_results_due.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("%t deframer: result word with none due: %s%0d %s%0d %s%h %s%0d",
                     $realtime, "status=", out_data.status, "valid=", out_data.body_valid,
                     "byte=", out_data.body_byte, "idx=", out_data.body_index);
        end else begin
          due = parse_results_due.pop_front();
          if (out_data.status !== due.status || out_data.body_valid !== due.body_valid ||
              out_data.body_byte !== due.body_byte ||
              out_data.body_index !== due.body_index) begin
            fail_total++;
            if (fail_total <= 10) begin
              $display("%t deframer mismatch: expected status=%0d valid=%0d byte=%h idx=%0d",
                       $realtime, due.status, due.body_valid, due.body_byte,
                       due.body_index);
              $display("%t deframer mismatch: got      status=%0d valid=%0d byte=%h idx=%0d",
                       $realtime, out_data.status, out_data.body_valid, out_data.body_byte,
                       out_data.body_index);
            end
          end
        end
      end
      if (in_valid && !in_stall) parse_results_due.push_back(parse_word(in_data));
    end
    mismatches   <= fail_total;
    results_owed <= parse_results_due.size();
  end

endmodule

`default_nettype wire

// ----- tb/serial_frame_deframer_test.sv -----
`default_nettype none

// Stimulus and verdict for the serial frame deframer. A checker module beside the
// block watches all three channels, keeps its own copy of the parser and counts
// mismatches; this module only produces words and decides pass or fail.
module serial_frame_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  // Every input is given a known value from time zero; reset starts high.
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  sfd_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sfd_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [19:0]        cfg_data = 20'd0;

  int unsigned mismatches;
  int unsigned results_owed;

  // Sender pacing and the mix of the random part.
  int          burst_left = 4;
  int          tick_pct = 5;
  int          counted_words = 0;

  // Receiver stall pattern.
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  serial_frame_deframer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  serial_frame_deframer_checker frame_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  // The receiver switches at random between stall patterns: no stalls at all, light or
  // heavy random stalls, or a fixed duty cycle.
  // Combined with the front queue this makes in_stall rise on and off as well.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 25);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
        default:     out_stall <= ((mode_left % 7) < 3);
      endcase
    end
  end

  // Presents one word and holds it until the block takes it. Valid stays high
  // into the next word unless the current burst has run out; then the sender
  // goes quiet for a random gap. Long bursts give stretches with no gaps at all.
  task automatic send_word(sfd_pkg::in_item_t w, bit counted);
    int gap;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    if (counted) counted_words++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(30, 80);
      else burst_left = $urandom_range(0, 8);
    end
  endtask

  function automatic sfd_pkg::in_item_t byte_word(logic [7:0] b);
    sfd_pkg::in_item_t w;
    w.cmd     = sfd_pkg::ITEM_BYTE;
    w.rx_byte = b;
    return w;
  endfunction

  // A tick carries a random byte that the block must ignore.
  task automatic send_tick();
    sfd_pkg::in_item_t w;
    w.cmd     = sfd_pkg::ITEM_TICK;
    w.rx_byte = 8'($urandom_range(0, 255));
    send_word(w, 1'b1);
  endtask

  // Sends one frame byte, sometimes preceded by a short run of ticks so that the
  // timeout can strike at any point inside a frame.
  task automatic send_frame_byte(logic [7:0] b);
    if ($urandom_range(0, 99) < tick_pct)
      repeat ($urandom_range(1, 4)) send_tick();
    send_word(byte_word(b), 1'b1);
  endtask

  // A frame with random body. Most have a correct checksum and trailer; some
  // carry a wrong checksum, a wrong trailer or both, and a few are cut short
  // inside the body so that the next sync bytes land in the middle of a frame.
  task automatic send_frame(int unsigned len);
    logic [7:0] body_byte;
    logic [7:0] sum;
    int unsigned stop_at;
    int unsigned i;
    sum = 8'd0;
    stop_at = len;
    if ($urandom_range(0, 99) < 5) stop_at = $urandom_range(0, len - 1);
    if ($urandom_range(0, 99) < 10) send_frame_byte(sfd_pkg::SYNC_A);
    send_frame_byte(sfd_pkg::SYNC_A);
    send_frame_byte(sfd_pkg::SYNC_B);
    send_frame_byte(len[7:0]);
    for (i = 0; i < stop_at; i++) begin
      body_byte = 8'($urandom_range(0, 255));
      // Each of the first two bytes is the wheel id in roughly a quarter of frames.
      if (i < 2 && $urandom_range(0, 3) == 0) body_byte = sfd_pkg::WHEEL_ID;
      sum = sum + body_byte;
      send_frame_byte(body_byte);
    end
    if (stop_at == len) begin
      if ($urandom_range(0, 99) < 15) send_frame_byte(8'(sum + $urandom_range(1, 255)));
      else send_frame_byte(sum);
      if ($urandom_range(0, 99) < 15) send_frame_byte(8'($urandom_range(0, 255)));
      else send_frame_byte(sfd_pkg::TRAILER);
    end
  endtask

  // One random piece of the stream: mostly well-formed frames, the rest short
  // lengths, broken sync pairs and noise that the hunting parser drops.
  task automatic random_sequence();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      if ($urandom_range(0, 9) == 0) send_frame($urandom_range(11, 40));
      else send_frame($urandom_range(2, 10));
    end else if (pick < 80) begin
      send_frame_byte(sfd_pkg::SYNC_A);
      send_frame_byte(sfd_pkg::SYNC_B);
      send_frame_byte(8'($urandom_range(0, 1)));
      send_frame_byte(8'($urandom_range(0, 255)));
    end else if (pick < 90) begin
      send_frame_byte(sfd_pkg::SYNC_A);
      send_frame_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) send_word(byte_word(8'($urandom_range(0, 255))), 1'b0);
    end
  endtask

  // Lets the stream run dry and waits until every predicted word has come out,
  // plus a margin for the output register.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(logic [19:0] ticks);
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] opening[$];
    logic [19:0] limit;
    int phase_no;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Opening sequence at the reset timeout: a tick while hunting, a dropped
    // noise byte, a wheel frame behind a doubled first sync byte, a zero length
    // whose dropped follower is itself a sync byte, a checksum error, and a
    // trailer error on a frame whose checksum is right.
    opening = '{8'hFF,
                8'h55, 8'h55, 8'hAA, 8'h02, 8'h02, 8'h02, 8'h04, 8'h7D,
                8'h55, 8'hAA, 8'h00, 8'h55,
                8'h55, 8'hAA, 8'h02, 8'hFF, 8'h80, 8'h00, 8'h7D,
                8'h55, 8'hAA, 8'h02, 8'h01, 8'h02, 8'h03, 8'h00};
    send_tick();
    foreach (opening[i]) send_word(byte_word(opening[i]), 1'b0);
    wait_idle();

    // Random part in several timeout settings, both extremes among them. The
    // tick rate is chosen for each setting so that timeouts are common but
    // most frames still get through.
    for (phase_no = 0; phase_no < 5; phase_no++) begin
      case (phase_no)
        0: begin
          limit = sfd_pkg::GAP_MAX;
          tick_pct = 5;
        end
        1: begin
          limit = 20'd0;
          tick_pct = 3;
        end
        2: begin
          limit = 20'd5;
          tick_pct = 8;
        end
        3: begin
          limit = 20'($urandom_range(1, 30));
          tick_pct = 12;
        end
        default: begin
          limit = 20'($urandom_range(31, 400));
          tick_pct = 20;
        end
      endcase
      write_timeout(limit);
      counted_words = 0;
      // The longest body the length byte allows, once, while nothing times out.
      if (phase_no == 0) send_frame(255);
      while (counted_words < 240) random_sequence();
      wait_idle();
    end

    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

// ----- serial_frame_deframer.f -----
+incdir+sv
sv/sfd_pkg.sv
sv/sfd_front.sv
sv/sfd_back.sv
sv/serial_frame_deframer.sv
tb/serial_frame_deframer_checker.sv
tb/serial_frame_deframer_test.sv
